// ----- design/mep_pkg.sv -----
// Shared types and constants for the interrupt controller table parser.
`default_nettype none

package mep_pkg;

   // One table byte as it arrives on the request channel
   typedef struct packed {
      logic       table_start;
      logic [7:0] data_byte;
   } req_type;

   // One reported item on the response channel
   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  entry_type;
      logic [7:0]  apic_id;
      logic [7:0]  processor_id;
      logic [31:0] address;
      logic [31:0] gsi;
      logic [7:0]  bus;
      logic [7:0]  source;
      logic [15:0] irq_flags;
      logic [8:0]  cpus_recorded;
      logic [15:0] io_count;
      logic [15:0] override_count;
   } rsp_type;

   // Status from the walker towards the result register
   typedef struct packed {
      logic    has_item;
      rsp_type rsp;
   } walk_out_type;

   // Event codes
   localparam logic [2:0] EV_HEADER_DONE  = 3'd0;
   localparam logic [2:0] EV_CPU_RECORDED = 3'd1;
   localparam logic [2:0] EV_CPU_SKIPPED  = 3'd2;
   localparam logic [2:0] EV_IO_CTRL      = 3'd3;
   localparam logic [2:0] EV_OVERRIDE     = 3'd4;
   localparam logic [2:0] EV_UNKNOWN      = 3'd5;
   localparam logic [2:0] EV_BAD_LENGTH   = 3'd6;
   localparam logic [2:0] EV_TABLE_END    = 3'd7;

   // Record type codes
   localparam logic [7:0] KIND_CPU      = 8'd0;
   localparam logic [7:0] KIND_IO_CTRL  = 8'd1;
   localparam logic [7:0] KIND_OVERRIDE = 8'd2;

   // Header layout
   localparam logic [31:0] HEADER_BYTES     = 32'd44;
   localparam logic [31:0] HEADER_LAST      = 32'd43;
   localparam logic [31:0] LENGTH_FIRST     = 32'd4;
   localparam logic [31:0] LENGTH_LAST      = 32'd7;
   localparam logic [31:0] LOCAL_ADDR_FIRST = 32'd36;

   // Record layout
   localparam logic [7:0] REC_SIZE_BYTE  = 8'd1;
   localparam logic [7:0] REC_MIN_SIZE   = 8'd2;
   localparam logic [7:0] REC_ID_END     = 8'd4;
   localparam logic [7:0] REC_FIELD_END  = 8'd12;

   // Processor recording cap
   localparam logic [8:0]  CPU_CAP   = 9'd256;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ----- design/mep_input_reg.sv -----
// Input register stage: holds one request item until the walker takes it.
`default_nettype none

module mep_input_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire mep_pkg::req_type req_data,
   input  wire logic            advance,
   output logic                 hold_valid,
   output mep_pkg::req_type     hold_item
);

   logic             valid_ff;
   logic             valid_in;
   mep_pkg::req_type item_ff;

   // Take a new item whenever the slot is empty or being drained
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on acceptance
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

`default_nettype wire

// ----- design/mep_walker.sv -----
// Table walker: offset tracking, field capture, counters and event decode.
`default_nettype none

module mep_walker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire mep_pkg::req_type item,
   output mep_pkg::walk_out_type walk_out
);

   logic [31:0] byte_offset_ff, byte_offset_in, cur_offset;
   logic [31:0] table_length_ff, table_length_in, cur_length;
   logic [7:0]  entry_offset_ff, entry_offset_in, cur_eo;
   logic [7:0]  entry_kind_ff, entry_kind_in, cur_kind;
   logic [7:0]  entry_size_ff, entry_size_in, cur_size;
   logic [63:0] field_shift_ff, field_shift_in, cur_fields;
   logic [15:0] id_pair_ff, id_pair_in, cur_ids;
   logic        walk_stopped_ff, walk_stopped_in;
   logic        end_pending_ff, end_pending_in;
   logic [8:0]  cpus_seen_ff, cpus_seen_in, cur_cpus;
   logic [15:0] ios_seen_ff, ios_seen_in, cur_ios;
   logic [15:0] overrides_seen_ff, overrides_seen_in, cur_overrides;
   logic [31:0] first_io_address_ff, first_io_address_in, cur_first_addr;
   logic [31:0] first_io_base_ff, first_io_base_in, cur_first_base;

   logic             start;
   logic             working;
   logic             bad;
   logic             done;
   logic             last;
   logic             has_ev;
   logic [7:0]       b;
   logic [2:0]       hdr_lane;
   logic [2:0]       rec_lane;
   mep_pkg::rsp_type ev;
   mep_pkg::rsp_type end_item;

   // Work out the next state and the item this byte produces
   always_comb begin
      start = item.table_start;
      b     = item.data_byte;

      // Restart clears the table state before the byte is parsed
      cur_offset     = start ? '0 : byte_offset_ff;
      cur_length     = start ? '0 : table_length_ff;
      cur_eo         = start ? '0 : entry_offset_ff;
      cur_kind       = start ? '0 : entry_kind_ff;
      cur_size       = start ? '0 : entry_size_ff;
      cur_fields     = start ? '0 : field_shift_ff;
      cur_ids        = start ? '0 : id_pair_ff;
      cur_cpus       = start ? '0 : cpus_seen_ff;
      cur_ios        = start ? '0 : ios_seen_ff;
      cur_overrides  = start ? '0 : overrides_seen_ff;
      cur_first_addr = start ? '0 : first_io_address_ff;
      cur_first_base = start ? '0 : first_io_base_ff;

      byte_offset_in      = cur_offset;
      table_length_in     = cur_length;
      entry_offset_in     = cur_eo;
      entry_kind_in       = cur_kind;
      entry_size_in       = cur_size;
      field_shift_in      = cur_fields;
      id_pair_in          = cur_ids;
      cpus_seen_in        = cur_cpus;
      ios_seen_in         = cur_ios;
      overrides_seen_in   = cur_overrides;
      first_io_address_in = cur_first_addr;
      first_io_base_in    = cur_first_base;
      walk_stopped_in     = walk_stopped_ff;
      end_pending_in      = end_pending_ff;

      has_ev   = 1'b0;
      bad      = 1'b0;
      done     = 1'b0;
      ev       = '0;
      hdr_lane = 3'(cur_offset - mep_pkg::LOCAL_ADDR_FIRST);
      rec_lane = 3'(cur_eo - 8'd4);
      last     = (cur_offset >= mep_pkg::HEADER_LAST) &&
                 ({1'b0, cur_offset} + 33'd1 >= {1'b0, cur_length});

      // Owed table end is delivered now and stops the walk
      if (end_pending_ff) begin
         end_pending_in  = 1'b0;
         walk_stopped_in = 1'b1;
      end
      if (start) begin
         walk_stopped_in = 1'b0;
      end

      working = start || !walk_stopped_ff;

      if (working) begin
         if (cur_offset < mep_pkg::HEADER_BYTES) begin
            // Header: capture table length and local controller address
            if (cur_offset >= mep_pkg::LENGTH_FIRST && cur_offset <= mep_pkg::LENGTH_LAST) begin
               for (int i = 0; i < 4; i++) begin
                  if (cur_offset[1:0] == 2'(i)) begin
                     table_length_in[8*i +: 8] = b;
                  end
               end
            end
            if (cur_offset >= mep_pkg::LOCAL_ADDR_FIRST) begin
               for (int i = 0; i < 8; i++) begin
                  if (hdr_lane == 3'(i)) begin
                     field_shift_in[8*i +: 8] = b;
                  end
               end
            end
            if (cur_offset == mep_pkg::HEADER_LAST) begin
               has_ev        = 1'b1;
               ev.event_res  = mep_pkg::EV_HEADER_DONE;
               ev.address    = field_shift_in[31:0];
            end
         end else begin
            // Record: type, length, IDs, then up to eight field bytes
            if (cur_eo == '0) begin
               entry_kind_in  = b;
               entry_size_in  = '0;
               field_shift_in = '0;
               id_pair_in     = '0;
            end else if (cur_eo == mep_pkg::REC_SIZE_BYTE) begin
               entry_size_in = b;
               if (b < mep_pkg::REC_MIN_SIZE) begin
                  bad           = 1'b1;
                  has_ev        = 1'b1;
                  ev.event_res  = mep_pkg::EV_BAD_LENGTH;
                  ev.entry_type = cur_kind;
               end
            end else if (cur_eo < mep_pkg::REC_ID_END) begin
               if (cur_eo[0]) begin
                  id_pair_in[15:8] = b;
               end else begin
                  id_pair_in[7:0] = b;
               end
            end else if (cur_eo < mep_pkg::REC_FIELD_END) begin
               for (int i = 0; i < 8; i++) begin
                  if (rec_lane == 3'(i)) begin
                     field_shift_in[8*i +: 8] = b;
                  end
               end
            end

            done = !bad && (cur_eo != '0) &&
                   ({1'b0, cur_eo} + 9'd1 == {1'b0, entry_size_in});

            if (done) begin
               has_ev        = 1'b1;
               ev.entry_type = entry_kind_in;
               case (entry_kind_in)
                  mep_pkg::KIND_CPU: begin
                     ev.apic_id      = id_pair_in[15:8];
                     ev.processor_id = id_pair_in[7:0];
                     if (field_shift_in[0] && cur_cpus < mep_pkg::CPU_CAP) begin
                        ev.event_res = mep_pkg::EV_CPU_RECORDED;
                        cpus_seen_in = cur_cpus + 9'd1;
                     end else begin
                        ev.event_res = mep_pkg::EV_CPU_SKIPPED;
                     end
                  end
                  mep_pkg::KIND_IO_CTRL: begin
                     ev.event_res = mep_pkg::EV_IO_CTRL;
                     ev.apic_id   = id_pair_in[7:0];
                     ev.address   = field_shift_in[31:0];
                     ev.gsi       = field_shift_in[63:32];
                     if (cur_ios == '0) begin
                        first_io_address_in = field_shift_in[31:0];
                        first_io_base_in    = field_shift_in[63:32];
                     end
                     if (cur_ios != mep_pkg::COUNT_MAX) begin
                        ios_seen_in = cur_ios + 16'd1;
                     end
                  end
                  mep_pkg::KIND_OVERRIDE: begin
                     ev.event_res = mep_pkg::EV_OVERRIDE;
                     ev.gsi       = field_shift_in[31:0];
                     ev.bus       = id_pair_in[7:0];
                     ev.source    = id_pair_in[15:8];
                     ev.irq_flags = field_shift_in[47:32];
                     if (cur_overrides != mep_pkg::COUNT_MAX) begin
                        overrides_seen_in = cur_overrides + 16'd1;
                     end
                  end
                  default: begin
                     ev.event_res = mep_pkg::EV_UNKNOWN;
                  end
               endcase
               entry_offset_in = '0;
            end else if (!bad) begin
               entry_offset_in = cur_eo + 8'd1;
            end
         end

         byte_offset_in = cur_offset + 32'd1;

         // Bad length or table end stops the walk; a second event waits a byte
         if (bad) begin
            end_pending_in  = 1'b1;
            walk_stopped_in = 1'b1;
         end else if (last) begin
            walk_stopped_in = 1'b1;
            if (has_ev) begin
               end_pending_in = 1'b1;
            end else begin
               has_ev       = 1'b1;
               ev.event_res = mep_pkg::EV_TABLE_END;
               ev.address   = first_io_address_in;
               ev.gsi       = first_io_base_in;
            end
         end
      end

      ev.cpus_recorded  = cur_cpus;
      ev.io_count       = ios_seen_in;
      ev.override_count = overrides_seen_in;

      // Table end owed from the previous byte, from the state before restart
      end_item                = '0;
      end_item.event_res      = mep_pkg::EV_TABLE_END;
      end_item.address        = first_io_address_ff;
      end_item.gsi            = first_io_base_ff;
      end_item.cpus_recorded  = cpus_seen_ff;
      end_item.io_count       = ios_seen_ff;
      end_item.override_count = overrides_seen_ff;

      if (end_pending_ff) begin
         walk_out.has_item = 1'b1;
         walk_out.rsp      = end_item;
      end else begin
         walk_out.has_item = working && has_ev;
         walk_out.rsp      = ev;
      end
   end

   // Advance the walk state once per item taken
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff      <= '0;
         table_length_ff     <= '0;
         entry_offset_ff     <= '0;
         entry_kind_ff       <= '0;
         entry_size_ff       <= '0;
         field_shift_ff      <= '0;
         id_pair_ff          <= '0;
         walk_stopped_ff     <= 1'b1;
         end_pending_ff      <= 1'b0;
         cpus_seen_ff        <= '0;
         ios_seen_ff         <= '0;
         overrides_seen_ff   <= '0;
         first_io_address_ff <= '0;
         first_io_base_ff    <= '0;
      end else if (fire) begin
         byte_offset_ff      <= byte_offset_in;
         table_length_ff     <= table_length_in;
         entry_offset_ff     <= entry_offset_in;
         entry_kind_ff       <= entry_kind_in;
         entry_size_ff       <= entry_size_in;
         field_shift_ff      <= field_shift_in;
         id_pair_ff          <= id_pair_in;
         walk_stopped_ff     <= walk_stopped_in;
         end_pending_ff      <= end_pending_in;
         cpus_seen_ff        <= cpus_seen_in;
         ios_seen_ff         <= ios_seen_in;
         overrides_seen_ff   <= overrides_seen_in;
         first_io_address_ff <= first_io_address_in;
         first_io_base_ff    <= first_io_base_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/madt_entry_parser.sv -----
// Top level of the streaming interrupt controller table parser.
`default_nettype none

// Takes the interrupt controller table one byte per item, table_start marking
// byte 0, and returns at most one result item per byte: header done, processor
// recorded or skipped, I/O controller, override, unknown record, bad length and
// table end. A new byte is accepted every cycle while
// the response side keeps up, and a result item left waiting in the result
// register stalls the input. A byte is held in the input register, then walked
// and its result loaded into the result register once that register can take it.
// When a record or the header finishes on the last table byte, or a length is bad,
// the table end item comes out with the following byte.
module madt_entry_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mep_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mep_pkg::rsp_type      rsp_data
);

   logic                  hold_valid;
   mep_pkg::req_type      hold_item;
   logic                  fire;
   mep_pkg::walk_out_type walk_out;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   mep_pkg::rsp_type      rsp_data_ff;

   // Walk a held byte whenever the result register can take an item
   assign fire = hold_valid && (!rsp_valid_ff || rsp_ready);

   mep_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (fire),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   mep_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (hold_item),
      .walk_out (walk_out)
   );

   // Result register: load a new item, or drop the old one once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && walk_out.has_item) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && walk_out.has_item) begin
         rsp_data_ff <= walk_out.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/madt_event_checker.sv -----
// Channel monitor for the table parser: predicts every result item and compares it on delivery.
module madt_event_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire mep_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire mep_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    events_owed,
   output int                    events_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         MAX_REPORTS = 40;
   localparam logic [7:0] ID_FIRST    = 8'd2;

   // Parser state as the table walk sees it
   logic [31:0] byte_pos;
   logic [31:0] table_len;
   logic [7:0]  rec_pos;
   logic [7:0]  rec_kind;
   logic [7:0]  rec_len;
   logic [63:0] rec_fields;
   logic [15:0] rec_ids;
   logic [8:0]  cpus_kept;
   logic [15:0] ios_kept;
   logic [15:0] overrides_kept;
   logic [31:0] io_addr_held;
   logic [31:0] io_base_held;
   logic        walk_idle;
   logic        end_owed;

   // Result items predicted but not yet delivered, oldest first
   mep_pkg::rsp_type owed_events[$];

   function automatic void clear_table();
      byte_pos       = '0;
      table_len      = '0;
      rec_pos        = '0;
      rec_kind       = '0;
      rec_len        = '0;
      rec_fields     = '0;
      rec_ids        = '0;
      cpus_kept      = '0;
      ios_kept       = '0;
      overrides_kept = '0;
      io_addr_held   = '0;
      io_base_held   = '0;
      end_owed       = 1'b0;
   endfunction

   function automatic mep_pkg::rsp_type table_end_item();
      mep_pkg::rsp_type r;
      r                = '0;
      r.event_res      = mep_pkg::EV_TABLE_END;
      r.address        = io_addr_held;
      r.gsi            = io_base_held;
      r.cpus_recorded  = cpus_kept;
      r.io_count       = ios_kept;
      r.override_count = overrides_kept;
      return r;
   endfunction

   // Advance the walk by one table byte and queue the result item it causes
   task automatic parse_table_byte(input mep_pkg::req_type item);
      mep_pkg::rsp_type r;
      logic [7:0]       b;
      logic [31:0]      pos;
      logic [7:0]       eo;
      logic             reported;
      logic             bad;
      logic             last_byte;
      logic             end_sent;
      b        = item.data_byte;
      r        = '0;
      reported = 1'b0;
      bad      = 1'b0;
      end_sent = 1'b0;
      // settle a table end left over from the previous byte
      if (end_owed) begin
         owed_events.push_back(table_end_item());
         end_owed  = 1'b0;
         walk_idle = 1'b1;
         end_sent  = 1'b1;
      end
      if (item.table_start) begin
         clear_table();
         walk_idle = 1'b0;
      end
      if (!walk_idle) begin
         pos             = byte_pos;
         r.cpus_recorded = cpus_kept;
         last_byte       = (pos >= mep_pkg::HEADER_LAST) &&
                           ({1'b0, pos} + 33'd1 >= {1'b0, table_len});
         if (pos < mep_pkg::HEADER_BYTES) begin
            // header: capture the declared length and the local controller address
            if (pos >= mep_pkg::LENGTH_FIRST && pos <= mep_pkg::LENGTH_LAST)
               table_len[8*(pos-mep_pkg::LENGTH_FIRST) +: 8] = b;
            if (pos >= mep_pkg::LOCAL_ADDR_FIRST)
               rec_fields[8*(pos-mep_pkg::LOCAL_ADDR_FIRST) +: 8] = b;
            if (pos == mep_pkg::HEADER_LAST) begin
               reported    = 1'b1;
               r.event_res = mep_pkg::EV_HEADER_DONE;
               r.address   = rec_fields[31:0];
            end
         end else begin
            eo = rec_pos;
            if (eo == 8'd0) begin
               rec_kind   = b;
               rec_len    = '0;
               rec_fields = '0;
               rec_ids    = '0;
            end else if (eo == mep_pkg::REC_SIZE_BYTE) begin
               rec_len = b;
               if (b < mep_pkg::REC_MIN_SIZE) begin
                  bad          = 1'b1;
                  reported     = 1'b1;
                  r.event_res  = mep_pkg::EV_BAD_LENGTH;
                  r.entry_type = rec_kind;
               end
            end else if (eo < mep_pkg::REC_ID_END) begin
               rec_ids[8*(eo-ID_FIRST) +: 8] = b;
            end else if (eo < mep_pkg::REC_FIELD_END) begin
               rec_fields[8*(eo-mep_pkg::REC_ID_END) +: 8] = b;
            end
            // report the record on its last byte
            if (!bad && eo != 8'd0 && ({1'b0, eo} + 9'd1 == {1'b0, rec_len})) begin
               reported     = 1'b1;
               r.entry_type = rec_kind;
               case (rec_kind)
                  mep_pkg::KIND_CPU: begin
                     r.apic_id      = rec_ids[15:8];
                     r.processor_id = rec_ids[7:0];
                     if (rec_fields[0] && cpus_kept < mep_pkg::CPU_CAP) begin
                        r.event_res = mep_pkg::EV_CPU_RECORDED;
                        cpus_kept   = cpus_kept + 9'd1;
                     end else begin
                        r.event_res = mep_pkg::EV_CPU_SKIPPED;
                     end
                  end
                  mep_pkg::KIND_IO_CTRL: begin
                     r.event_res = mep_pkg::EV_IO_CTRL;
                     r.apic_id   = rec_ids[7:0];
                     r.address   = rec_fields[31:0];
                     r.gsi       = rec_fields[63:32];
                     if (ios_kept == '0) begin
                        io_addr_held = rec_fields[31:0];
                        io_base_held = rec_fields[63:32];
                     end
                     if (ios_kept != mep_pkg::COUNT_MAX)
                        ios_kept = ios_kept + 16'd1;
                  end
                  mep_pkg::KIND_OVERRIDE: begin
                     r.event_res = mep_pkg::EV_OVERRIDE;
                     r.gsi       = rec_fields[31:0];
                     r.bus       = rec_ids[7:0];
                     r.source    = rec_ids[15:8];
                     r.irq_flags = rec_fields[47:32];
                     if (overrides_kept != mep_pkg::COUNT_MAX)
                        overrides_kept = overrides_kept + 16'd1;
                  end
                  default: begin
                     r.event_res = mep_pkg::EV_UNKNOWN;
                  end
               endcase
               rec_pos = '0;
            end else if (!bad) begin
               rec_pos = eo + 8'd1;
            end
         end
         byte_pos = pos + 32'd1;
         // stop the walk; a second item on this byte waits for the next one
         if (bad) begin
            end_owed  = 1'b1;
            walk_idle = 1'b1;
         end else if (last_byte) begin
            walk_idle = 1'b1;
            if (reported) begin
               end_owed = 1'b1;
            end else begin
               reported = 1'b1;
               r        = table_end_item();
            end
         end
         if (reported && !end_sent) begin
            r.io_count       = ios_kept;
            r.override_count = overrides_kept;
            owed_events.push_back(r);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      mep_pkg::rsp_type want;
      if (reset) begin
         clear_table();
         walk_idle = 1'b1;
         owed_events.delete();
         events_owed = 0;
      end else begin
         // match a delivered item against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            events_checked++;
            if (owed_events.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: unexpected result item: expected none, actual %0d/0x%0h",
                           $time, rsp_data.event_res, rsp_data.entry_type);
            end else begin
               want = owed_events.pop_front();
               check_field("event_res", 32'(want.event_res), 32'(rsp_data.event_res));
               check_field("entry_type", 32'(want.entry_type), 32'(rsp_data.entry_type));
               check_field("apic_id", 32'(want.apic_id), 32'(rsp_data.apic_id));
               check_field("processor_id", 32'(want.processor_id),
                           32'(rsp_data.processor_id));
               check_field("address", want.address, rsp_data.address);
               check_field("gsi", want.gsi, rsp_data.gsi);
               check_field("bus", 32'(want.bus), 32'(rsp_data.bus));
               check_field("source", 32'(want.source), 32'(rsp_data.source));
               check_field("irq_flags", 32'(want.irq_flags), 32'(rsp_data.irq_flags));
               check_field("cpus_recorded", 32'(want.cpus_recorded),
                           32'(rsp_data.cpus_recorded));
               check_field("io_count", 32'(want.io_count), 32'(rsp_data.io_count));
               check_field("override_count", 32'(want.override_count),
                           32'(rsp_data.override_count));
            end
         end
         // predict from each accepted table byte
         if (req_valid && req_ready)
            parse_table_byte(req_data);
         events_owed = owed_events.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the table parser testbench: clock, reset, table stimulus and the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RANDOM_ITEMS     = 450;
   localparam int     TAIL_ITEMS       = 80;
   localparam int     PRESSURE_RECORDS = 16;
   localparam int     HOLD_OFF_CYCLES  = 300;
   localparam int     DRAIN_CYCLES     = 16;
   // About 1.3k items, each at worst the longest send gap and the longest
   // result stall, plus the hold-off and drains: allow several times that.
   localparam longint CYCLE_LIMIT      = 500_000;

   // Body fill patterns for built records
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONES   = 2;

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_ready;
   mep_pkg::req_type req_data     = '0;
   logic             rsp_valid;
   logic             rsp_ready    = 1'b0;
   mep_pkg::rsp_type rsp_data;
   int               fail_count;
   int               events_owed;
   int               events_checked;
   logic             gaps_on      = 1'b1;
   logic             hold_off_req = 1'b0;
   int               bytes_sent   = 0;
   int               tables_sent  = 0;
   longint           cycle_count  = 0;
   logic [7:0]       tbl[$];

   madt_entry_parser DUT (.*);

   madt_event_checker u_check (.*);

   always #2 clock = ~clock;

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d result items outstanding",
                  cycle_count, events_owed);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] fill_byte(input int fill);
      case (fill)
         FILL_ZERO: return 8'h00;
         FILL_ONES: return 8'hFF;
         default:   return 8'($urandom);
      endcase
   endfunction

   // Offer one table byte and hold it until accepted
   task automatic send_byte(input logic start, input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{table_start: start, data_byte: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_table();
      foreach (tbl[i]) send_byte(i == 0, tbl[i]);
      tables_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      wait (events_owed == 0);
      @(negedge clock);
   endtask

   task automatic start_header(input logic [31:0] local_addr, input int fill);
      tbl.delete();
      repeat (mep_pkg::HEADER_BYTES) tbl.push_back(fill_byte(fill));
      for (int i = 0; i < 4; i++)
         tbl[mep_pkg::LOCAL_ADDR_FIRST + i] = local_addr[8*i +: 8];
   endtask

   task automatic set_length(input logic [31:0] len);
      for (int i = 0; i < 4; i++) tbl[mep_pkg::LENGTH_FIRST + i] = len[8*i +: 8];
   endtask

   task automatic add_record(input logic [7:0] kind, input logic [7:0] len, input int fill);
      tbl.push_back(kind);
      tbl.push_back(len);
      for (int i = 2; i < int'(len); i++) tbl.push_back(fill_byte(fill));
   endtask

   // Mostly well-formed records, some resized, a few with a bad length
   task automatic add_random_record();
      int         pick;
      logic [7:0] kind;
      logic [7:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         kind = mep_pkg::KIND_CPU;
         len  = 8'd8;
      end else if (pick < 55) begin
         kind = mep_pkg::KIND_IO_CTRL;
         len  = 8'd12;
      end else if (pick < 75) begin
         kind = mep_pkg::KIND_OVERRIDE;
         len  = 8'd10;
      end else begin
         kind = 8'($urandom_range(0, 255));
         len  = 8'($urandom_range(2, 16));
      end
      if ($urandom_range(0, 4) == 0)
         len = 8'($urandom_range(2, 24));
      if (pick < 3)
         len = 8'($urandom_range(0, 1));
      add_record(kind, len, FILL_RANDOM);
   endtask

   task automatic random_table();
      int mode;
      start_header($urandom, FILL_RANDOM);
      repeat ($urandom_range(0, 10)) add_random_record();
      // declared length: exact, cut short, below the header, beyond the bytes sent, or random
      mode = $urandom_range(0, 99);
      if (mode < 75)
         set_length(tbl.size());
      else if (mode < 85)
         set_length($urandom_range(mep_pkg::HEADER_BYTES, tbl.size()));
      else if (mode < 90)
         set_length($urandom_range(0, mep_pkg::HEADER_LAST));
      else if (mode < 95)
         set_length(tbl.size() + $urandom_range(1, 8));
      else
         set_length($urandom);
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 6)) tbl.push_back(8'($urandom));
      send_table();
   endtask

   initial begin
      int random_start;
      int rec_start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // stray bytes before any table are ignored
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'h00);

      // header-only tables back to back; the second restarts on the owed end
      start_header(32'hFFFF_FFFF, FILL_ONES);
      set_length(mep_pkg::HEADER_BYTES);
      send_table();
      start_header(32'h0000_0000, FILL_ZERO);
      set_length(32'd0);
      send_table();

      // every record kind, extreme bodies, short and long records
      start_header($urandom, FILL_RANDOM);
      add_record(mep_pkg::KIND_CPU, 8'd8, FILL_ONES);
      add_record(mep_pkg::KIND_CPU, 8'd8, FILL_ZERO);
      add_record(mep_pkg::KIND_IO_CTRL, 8'd12, FILL_ONES);
      add_record(mep_pkg::KIND_IO_CTRL, 8'd12, FILL_ZERO);
      add_record(mep_pkg::KIND_OVERRIDE, 8'd10, FILL_ONES);
      add_record(mep_pkg::KIND_OVERRIDE, 8'd10, FILL_ZERO);
      add_record(8'hFF, 8'd2, FILL_RANDOM);
      add_record(mep_pkg::KIND_CPU, 8'd3, FILL_ONES);
      add_record(mep_pkg::KIND_IO_CTRL, 8'd5, FILL_ONES);
      add_record(mep_pkg::KIND_OVERRIDE, 8'd64, FILL_ONES);
      set_length(tbl.size());
      send_table();

      // bad lengths: zero in mid-table, one on the last byte
      start_header($urandom, FILL_RANDOM);
      add_record(mep_pkg::KIND_CPU, 8'd8, FILL_RANDOM);
      add_record(8'($urandom), 8'd0, FILL_RANDOM);
      add_record(mep_pkg::KIND_IO_CTRL, 8'd12, FILL_RANDOM);
      set_length(tbl.size());
      send_table();
      start_header($urandom, FILL_RANDOM);
      add_record(mep_pkg::KIND_OVERRIDE, 8'd1, FILL_RANDOM);
      set_length(tbl.size());
      send_table();

      // record cut off by the table end, then ignored trailing bytes
      start_header($urandom, FILL_RANDOM);
      add_record(mep_pkg::KIND_IO_CTRL, 8'd12, FILL_RANDOM);
      add_record(mep_pkg::KIND_OVERRIDE, 8'd10, FILL_RANDOM);
      set_length(tbl.size() - 4);
      send_table();

      // table abandoned mid-record; the next table restarts the walk
      start_header($urandom, FILL_RANDOM);
      add_record(mep_pkg::KIND_CPU, 8'd8, FILL_RANDOM);
      add_record(mep_pkg::KIND_IO_CTRL, 8'd12, FILL_RANDOM);
      set_length(tbl.size() + 20);
      repeat (5) void'(tbl.pop_back());
      send_table();

      // random tables with stray bytes and occasional full drains
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0)
            pause_until_drained();
         if ($urandom_range(0, 4) == 0)
            send_byte(1'b0, 8'($urandom));
         random_table();
      end

      // drain, then hold the result side off while a processor table streams in
      gaps_on = 1'b1;
      pause_until_drained();
      hold_off_req = 1'b1;
      start_header($urandom, FILL_RANDOM);
      repeat (PRESSURE_RECORDS) begin
         rec_start = tbl.size();
         add_record(mep_pkg::KIND_CPU, 8'($urandom_range(5, 8)), FILL_RANDOM);
         if ($urandom_range(0, 9) != 0)
            tbl[rec_start + 4] = tbl[rec_start + 4] | 8'h01;
      end
      set_length(tbl.size());
      send_table();

      // closing stretch at full rate on both sides
      gaps_on = 1'b0;
      random_start = bytes_sent;
      while (bytes_sent - random_start < TAIL_ITEMS) random_table();
      send_byte(1'b0, 8'($urandom));
      req_valid <= 1'b0;

      wait (events_owed == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d tables in %0d table bytes; %0d result items checked.",
               tables_sent, bytes_sent, events_checked);
      $display("It took in short, long, cut-off and bad-length records and a %0d-cycle stall.",
               HOLD_OFF_CYCLES);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
